>>> hw/rtl/lprz_pkg.sv
// ----------------------------------------------------------------------------
// lprz_pkg
// Shared widths, register indexes and stage payload types of the lidar point
// range, rotate and zone filter.
// ----------------------------------------------------------------------------
package lprz_pkg;

	localparam int COORD_W = 19;
	localparam int INT_W   = 8;
	localparam int Q_W     = 16;
	localparam int RANGE_W = 32;
	localparam int ROT_W   = 20;
	localparam int FRAC_W  = 28;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 3;

	// One square of a coordinate, and the sum of three squares.
	localparam int SQ_W    = 2 * COORD_W - 1;
	localparam int D2_W    = SQ_W + 1;
	// Quaternion part times coordinate, cross product, quaternion part times cross term.
	localparam int PROD_W  = Q_W + COORD_W;
	localparam int T_W     = PROD_W + 1;
	localparam int TP_W    = Q_W + T_W;
	// Rotated point scaled by 2^28.
	localparam int R_W     = TP_W + 3;

	localparam logic        ALIGN_RESET     = 1'b0;
	localparam logic [Q_W-1:0] QUAT_W_RESET = 16'd16384;
	localparam logic [Q_W-1:0] QUAT_V_RESET = 16'd0;
	localparam logic [RANGE_W-1:0] MIN_RANGE_SQ_RESET  = 32'd90000;
	localparam logic [RANGE_W-1:0] REAR_RANGE_SQ_RESET = 32'd1000000;

	localparam longint BOX_X_LO_MM = -1000;
	localparam longint BOX_X_HI_MM = 3500;
	localparam longint BOX_Y_LO_MM = -500;
	localparam longint BOX_Y_HI_MM = 500;
	localparam longint BOX_Z_LO_MM = -100;
	localparam longint BOX_Z_HI_MM = 3000;

	typedef enum logic [IDX_W-1:0] {
		REG_ALIGN_ENABLE  = 3'd0,
		REG_QUAT_W        = 3'd1,
		REG_QUAT_X        = 3'd2,
		REG_QUAT_Y        = 3'd3,
		REG_QUAT_Z        = 3'd4,
		REG_MIN_RANGE_SQ  = 3'd5,
		REG_REAR_RANGE_SQ = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic                      align_enable;
		logic signed [Q_W-1:0]     quat_w;
		logic signed [Q_W-1:0]     quat_x;
		logic signed [Q_W-1:0]     quat_y;
		logic signed [Q_W-1:0]     quat_z;
		logic [RANGE_W-1:0]        min_range_sq;
		logic [RANGE_W-1:0]        rear_range_sq;
	} cfg_t;

	typedef struct packed {
		logic                      keep;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic signed [T_W-1:0]     t_x;
		logic signed [T_W-1:0]     t_y;
		logic signed [T_W-1:0]     t_z;
		logic [INT_W-1:0]          intensity;
	} front_t;

	typedef struct packed {
		logic                      keep;
		logic signed [R_W-1:0]     r_x;
		logic signed [R_W-1:0]     r_y;
		logic signed [R_W-1:0]     r_z;
		logic [INT_W-1:0]          intensity;
	} rot_t;

endpackage

>>> hw/rtl/lidar_point_range_rotate_zone_filter.sv
// ----------------------------------------------------------------------------
// lidar_point_range_rotate_zone_filter
// Drops near and rear-sector lidar points, rotates kept points by a Q1.14
// quaternion and flags those inside the fixed obstacle box.
// ----------------------------------------------------------------------------
// The block takes one point per clock cycle while no result waits under
// out_stall, and returns one result per point. It has five register stages:
// squares and first cross products, range decision and cross term,
// quaternion products, the rotation sum, and the box test with rounding in
// the output register. When out_stall holds a waiting result the whole
// pipeline freezes and in_stall rises in the same cycle; bubbles do not
// cost throughput. Configuration may only be written while no point is in
// flight.
module lidar_point_range_rotate_zone_filter
	import lprz_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [IDX_W-1:0]          wr_index,
	input  logic [CFG_W-1:0]          wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] pt_x,
	input  logic signed [COORD_W-1:0] pt_y,
	input  logic signed [COORD_W-1:0] pt_z,
	input  logic [INT_W-1:0]          pt_intensity,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      kept,
	output logic                      in_zone,
	output logic signed [ROT_W-1:0]   rot_x,
	output logic signed [ROT_W-1:0]   rot_y,
	output logic signed [ROT_W-1:0]   rot_z,
	output logic [INT_W-1:0]          out_intensity
);

	cfg_t   cfg;
	logic   advance;
	logic   valid_s2, valid_s4;
	front_t front_s2;
	rot_t   rot_s4;

	// A transaction leaves or no result waits: every stage moves one step.
	assign advance  = !out_valid || !out_stall;
	assign in_stall = !advance;

	lprz_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	lprz_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.pt_x         (pt_x),
		.pt_y         (pt_y),
		.pt_z         (pt_z),
		.pt_intensity (pt_intensity),
		.valid_s2     (valid_s2),
		.front_s2     (front_s2)
	);

	lprz_rotate u_rotate (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.cfg      (cfg),
		.valid_s2 (valid_s2),
		.front_s2 (front_s2),
		.valid_s4 (valid_s4),
		.rot_s4   (rot_s4)
	);

	lprz_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.valid_s4      (valid_s4),
		.rot_s4        (rot_s4),
		.valid_s5      (out_valid),
		.kept          (kept),
		.in_zone       (in_zone),
		.rot_x         (rot_x),
		.rot_y         (rot_y),
		.rot_z         (rot_z),
		.out_intensity (out_intensity)
	);

endmodule

>>> hw/rtl/lprz_cfg.sv
// ----------------------------------------------------------------------------
// lprz_cfg
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
module lprz_cfg
	import lprz_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.align_enable  <= ALIGN_RESET;
			cfg_q.quat_w        <= QUAT_W_RESET;
			cfg_q.quat_x        <= QUAT_V_RESET;
			cfg_q.quat_y        <= QUAT_V_RESET;
			cfg_q.quat_z        <= QUAT_V_RESET;
			cfg_q.min_range_sq  <= MIN_RANGE_SQ_RESET;
			cfg_q.rear_range_sq <= REAR_RANGE_SQ_RESET;
		end else if (wr_en) begin
			// Writes to indexes past the last register are dropped.
			case (reg_idx_t'(wr_index))
				REG_ALIGN_ENABLE:  cfg_q.align_enable  <= wr_data[0];
				REG_QUAT_W:        cfg_q.quat_w        <= wr_data[Q_W-1:0];
				REG_QUAT_X:        cfg_q.quat_x        <= wr_data[Q_W-1:0];
				REG_QUAT_Y:        cfg_q.quat_y        <= wr_data[Q_W-1:0];
				REG_QUAT_Z:        cfg_q.quat_z        <= wr_data[Q_W-1:0];
				REG_MIN_RANGE_SQ:  cfg_q.min_range_sq  <= wr_data[RANGE_W-1:0];
				REG_REAR_RANGE_SQ: cfg_q.rear_range_sq <= wr_data[RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/lprz_front.sv
// ----------------------------------------------------------------------------
// lprz_front
// Stages 1 and 2: squares and first cross products, then the range filter
// decision and the cross product t = u x v.
// ----------------------------------------------------------------------------
module lprz_front
	import lprz_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  cfg_t                      cfg,
	input  logic                      in_valid,
	input  logic signed [COORD_W-1:0] pt_x,
	input  logic signed [COORD_W-1:0] pt_y,
	input  logic signed [COORD_W-1:0] pt_z,
	input  logic [INT_W-1:0]          pt_intensity,
	output logic                      valid_s2,
	output front_t                    front_s2
);

	logic signed [2*COORD_W-1:0] sq_x, sq_y, sq_z;

	logic                      valid_s1;
	logic signed [COORD_W-1:0] x_s1, y_s1, z_s1;
	logic [INT_W-1:0]          int_s1;
	logic [SQ_W-1:0]           xx_s1, yy_s1, zz_s1;
	logic signed [PROD_W-1:0]  p_yz_s1, p_zy_s1, p_zx_s1, p_xz_s1, p_xy_s1, p_yx_s1;

	logic [D2_W-1:0]  d2, yy3;
	logic             rear, near_min, near_rear;
	front_t           front_d;

	assign sq_x = pt_x * pt_x;
	assign sq_y = pt_y * pt_y;
	assign sq_z = pt_z * pt_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_s1    <= pt_x;
			y_s1    <= pt_y;
			z_s1    <= pt_z;
			int_s1  <= pt_intensity;
			xx_s1   <= sq_x[SQ_W-1:0];
			yy_s1   <= sq_y[SQ_W-1:0];
			zz_s1   <= sq_z[SQ_W-1:0];
			p_yz_s1 <= cfg.quat_y * pt_z;
			p_zy_s1 <= cfg.quat_z * pt_y;
			p_zx_s1 <= cfg.quat_z * pt_x;
			p_xz_s1 <= cfg.quat_x * pt_z;
			p_xy_s1 <= cfg.quat_x * pt_y;
			p_yx_s1 <= cfg.quat_y * pt_x;
			front_s2 <= front_d;
		end
	end

	always_comb begin
		d2  = D2_W'(xx_s1) + D2_W'(yy_s1) + D2_W'(zz_s1);
		yy3 = D2_W'(yy_s1) + {yy_s1, 1'b0};
		// Rear sector: more than 150 degrees away from +x.
		rear      = x_s1[COORD_W-1] && (yy3 < D2_W'(xx_s1));
		near_min  = d2 < D2_W'(cfg.min_range_sq);
		near_rear = rear && (d2 < D2_W'(cfg.rear_range_sq));

		front_d.keep      = cfg.align_enable && !near_min && !near_rear;
		front_d.x         = x_s1;
		front_d.y         = y_s1;
		front_d.z         = z_s1;
		front_d.t_x       = T_W'(p_yz_s1) - T_W'(p_zy_s1);
		front_d.t_y       = T_W'(p_zx_s1) - T_W'(p_xz_s1);
		front_d.t_z       = T_W'(p_xy_s1) - T_W'(p_yx_s1);
		front_d.intensity = int_s1;
	end

endmodule

>>> hw/rtl/lprz_rotate.sv
// ----------------------------------------------------------------------------
// lprz_rotate
// Stages 3 and 4: quaternion products of the cross term, then the sum
// r = v*2^28 + 2*w*t + 2*(u x t).
// ----------------------------------------------------------------------------
module lprz_rotate
	import lprz_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   advance,
	input  cfg_t   cfg,
	input  logic   valid_s2,
	input  front_t front_s2,
	output logic   valid_s4,
	output rot_t   rot_s4
);

	logic                      valid_s3;
	logic                      keep_s3;
	logic signed [COORD_W-1:0] x_s3, y_s3, z_s3;
	logic [INT_W-1:0]          int_s3;
	logic signed [TP_W-1:0]    wt_x_s3, wt_y_s3, wt_z_s3;
	logic signed [TP_W-1:0]    a_x_s3, b_x_s3, a_y_s3, b_y_s3, a_z_s3, b_z_s3;

	rot_t rot_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			keep_s3 <= front_s2.keep;
			x_s3    <= front_s2.x;
			y_s3    <= front_s2.y;
			z_s3    <= front_s2.z;
			int_s3  <= front_s2.intensity;
			wt_x_s3 <= cfg.quat_w * front_s2.t_x;
			wt_y_s3 <= cfg.quat_w * front_s2.t_y;
			wt_z_s3 <= cfg.quat_w * front_s2.t_z;
			a_x_s3  <= cfg.quat_y * front_s2.t_z;
			b_x_s3  <= cfg.quat_z * front_s2.t_y;
			a_y_s3  <= cfg.quat_z * front_s2.t_x;
			b_y_s3  <= cfg.quat_x * front_s2.t_z;
			a_z_s3  <= cfg.quat_x * front_s2.t_y;
			b_z_s3  <= cfg.quat_y * front_s2.t_x;
			rot_s4  <= rot_d;
		end
	end

	always_comb begin
		rot_d.keep      = keep_s3;
		rot_d.intensity = int_s3;
		rot_d.r_x = (R_W'(x_s3) <<< FRAC_W) + (R_W'(wt_x_s3) <<< 1)
			+ ((R_W'(a_x_s3) - R_W'(b_x_s3)) <<< 1);
		rot_d.r_y = (R_W'(y_s3) <<< FRAC_W) + (R_W'(wt_y_s3) <<< 1)
			+ ((R_W'(a_y_s3) - R_W'(b_y_s3)) <<< 1);
		rot_d.r_z = (R_W'(z_s3) <<< FRAC_W) + (R_W'(wt_z_s3) <<< 1)
			+ ((R_W'(a_z_s3) - R_W'(b_z_s3)) <<< 1);
	end

endmodule

>>> hw/rtl/lprz_out.sv
// ----------------------------------------------------------------------------
// lprz_out
// Stage 5: obstacle box test, rounding and saturation, output register.
// ----------------------------------------------------------------------------
module lprz_out
	import lprz_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic                    valid_s4,
	input  rot_t                    rot_s4,
	output logic                    valid_s5,
	output logic                    kept,
	output logic                    in_zone,
	output logic signed [ROT_W-1:0] rot_x,
	output logic signed [ROT_W-1:0] rot_y,
	output logic signed [ROT_W-1:0] rot_z,
	output logic [INT_W-1:0]        out_intensity
);

	localparam int RND_W = R_W + 1 - FRAC_W;
	localparam logic signed [R_W:0] HALF = (R_W + 1)'(64'sd1 <<< (FRAC_W - 1));
	localparam logic signed [RND_W-1:0] RND_MAX = RND_W'((64'sd1 <<< (ROT_W - 1)) - 1);
	localparam logic signed [RND_W-1:0] RND_MIN = RND_W'(-(64'sd1 <<< (ROT_W - 1)));
	localparam logic signed [R_W-1:0] ZONE_X_LO = R_W'(BOX_X_LO_MM * (64'sd1 <<< FRAC_W));
	localparam logic signed [R_W-1:0] ZONE_X_HI = R_W'(BOX_X_HI_MM * (64'sd1 <<< FRAC_W));
	localparam logic signed [R_W-1:0] ZONE_Y_LO = R_W'(BOX_Y_LO_MM * (64'sd1 <<< FRAC_W));
	localparam logic signed [R_W-1:0] ZONE_Y_HI = R_W'(BOX_Y_HI_MM * (64'sd1 <<< FRAC_W));
	localparam logic signed [R_W-1:0] ZONE_Z_LO = R_W'(BOX_Z_LO_MM * (64'sd1 <<< FRAC_W));
	localparam logic signed [R_W-1:0] ZONE_Z_HI = R_W'(BOX_Z_HI_MM * (64'sd1 <<< FRAC_W));

	function automatic logic signed [ROT_W-1:0] round_sat(input logic signed [R_W-1:0] r);
		logic signed [R_W:0]     biased;
		logic signed [RND_W-1:0] rnd;
		biased = (R_W + 1)'(r) + HALF;
		rnd    = $signed(biased[R_W:FRAC_W]);
		if (rnd > RND_MAX) begin
			return RND_MAX[ROT_W-1:0];
		end else if (rnd < RND_MIN) begin
			return RND_MIN[ROT_W-1:0];
		end else begin
			return rnd[ROT_W-1:0];
		end
	endfunction

	logic zone;

	// The box test works on the exact scaled value, before rounding.
	assign zone = (rot_s4.r_x >= ZONE_X_LO) && (rot_s4.r_x <= ZONE_X_HI)
		&& (rot_s4.r_y >= ZONE_Y_LO) && (rot_s4.r_y <= ZONE_Y_HI)
		&& (rot_s4.r_z > ZONE_Z_LO) && (rot_s4.r_z < ZONE_Z_HI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (advance) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_intensity <= rot_s4.intensity;
			kept          <= rot_s4.keep;
			if (rot_s4.keep) begin
				in_zone <= zone;
				rot_x   <= round_sat(rot_s4.r_x);
				rot_y   <= round_sat(rot_s4.r_y);
				rot_z   <= round_sat(rot_s4.r_z);
			end else begin
				in_zone <= 1'b0;
				rot_x   <= '0;
				rot_y   <= '0;
				rot_z   <= '0;
			end
		end
	end

endmodule
